>>> hw/rtl/keypad_matrix_decoder_sticky_modifiers_assert.svh
// assertion macros for the keypad matrix decoder
// no dependencies; included by the modules that carry checks
`ifndef KEYPAD_MATRIX_DECODER_STICKY_MODIFIERS_ASSERT_SVH
`define KEYPAD_MATRIX_DECODER_STICKY_MODIFIERS_ASSERT_SVH

`ifndef ASSERT_OFF
// property must hold at every rising edge outside reset
`define KMD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("kmd assertion failed");
// expression must never be true outside reset
`define KMD_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("kmd forbidden condition seen");
`else
`define KMD_ASSERT(lbl, clk, rst, prop)
`define KMD_NEVER(lbl, clk, rst, expr)
`endif

`endif

>>> hw/rtl/kmd_pkg.sv
// shared types, key codes and character tables of the keypad decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kmd_pkg;

   localparam int unsigned MATRIX_W  = 56;
   localparam int unsigned SEL_LINES = 8;
   localparam int unsigned IN_LINES  = 7;

   localparam logic [5:0] KEY_FN        = 6'd28;
   localparam logic [5:0] KEY_SHIFT     = 6'd29;
   localparam logic [5:0] KEY_BACKTICK  = 6'd0;
   localparam logic [5:0] KEY_BACKSPACE = 6'd13;
   localparam logic [5:0] KEY_SEMICOLON = 6'd39;
   localparam logic [5:0] KEY_COMMA     = 6'd52;
   localparam logic [5:0] KEY_PERIOD    = 6'd53;
   localparam logic [5:0] KEY_SLASH     = 6'd54;
   localparam logic [5:0] KEY_UP        = 6'd56;
   localparam logic [5:0] KEY_DOWN      = 6'd57;
   localparam logic [5:0] KEY_LEFT      = 6'd58;
   localparam logic [5:0] KEY_RIGHT     = 6'd59;
   localparam logic [5:0] KEY_ESC       = 6'd60;
   localparam logic [5:0] KEY_DELETE    = 6'd61;
   localparam logic [5:0] KEY_PHYS_END  = 6'd56;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd150;

   localparam logic ACT_POLL  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // one classified request, passed from front to back
   typedef struct packed {
      logic        action;
      logic        found;
      logic [5:0]  code;
      logic [31:0] now_ms;
   } kmd_item_type;

   // unshifted characters by key code, zero for non-printing keys
   localparam logic [6:0] BASE_CHAR [0:63] = '{
      7'h60, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
      7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h00,
      7'h00, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75,
      7'h69, 7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h5c,
      7'h00, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
      7'h6a, 7'h6b, 7'h6c, 7'h3b, 7'h27, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h7a, 7'h78, 7'h63, 7'h76, 7'h62,
      7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h20,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   // shifted characters by key code
   localparam logic [6:0] SHIFT_CHAR [0:63] = '{
      7'h7e, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5e, 7'h26,
      7'h2a, 7'h28, 7'h29, 7'h5f, 7'h2b, 7'h00,
      7'h00, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55,
      7'h49, 7'h4f, 7'h50, 7'h7b, 7'h7d, 7'h7c,
      7'h00, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
      7'h4a, 7'h4b, 7'h4c, 7'h3a, 7'h22, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h5a, 7'h58, 7'h43, 7'h56, 7'h42,
      7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h20,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
   };

   // physical position of a switch to key code
   function automatic logic [5:0] key_code_of(input logic [2:0] sel, input logic [2:0] inl);
      logic [1:0] row;
      logic [5:0] col;
      begin
         row = 2'd3 - sel[1:0];
         col = {2'b00, inl, 1'b0} + {5'd0, ~sel[2]};
         key_code_of = 6'(6'(row) * 6'd14) + col;
      end
   endfunction

   // fn layer remap
   function automatic logic [5:0] fn_layer(input logic [5:0] code);
      begin
         case (code)
            KEY_SEMICOLON: fn_layer = KEY_UP;
            KEY_PERIOD:    fn_layer = KEY_DOWN;
            KEY_COMMA:     fn_layer = KEY_LEFT;
            KEY_SLASH:     fn_layer = KEY_RIGHT;
            KEY_BACKTICK:  fn_layer = KEY_ESC;
            KEY_BACKSPACE: fn_layer = KEY_DELETE;
            default:       fn_layer = code;
         endcase
      end
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kmd_front.sv
// front part: priority encode of the pressed snapshot into a key code
// depends on kmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module kmd_front (
   input  wire logic                          req_action,
   input  wire logic [kmd_pkg::MATRIX_W-1:0]  req_matrix,
   input  wire logic [31:0]                   req_now_ms,
   output kmd_pkg::kmd_item_type              item
);
   import kmd_pkg::*;

   logic [2:0] sel;
   logic [2:0] inl;
   logic       any;
   logic [6:0] grp;

   always_comb begin
      sel = 3'd0;
      any = 1'b0;
      // lowest select line with a pressed switch wins
      for (int s = SEL_LINES - 1; s >= 0; s--) begin
         if (|req_matrix[s*IN_LINES +: IN_LINES]) begin
            sel = 3'(s);
            any = 1'b1;
         end
      end
      grp = req_matrix[sel*IN_LINES +: IN_LINES];
      inl = 3'd0;
      for (int i = IN_LINES - 1; i >= 0; i--) begin
         if (grp[i]) begin
            inl = 3'(i);
         end
      end
   end

   assign item.action = req_action;
   assign item.found  = any;
   assign item.code   = key_code_of(sel, inl);
   assign item.now_ms = req_now_ms;

endmodule

`default_nettype wire

>>> hw/rtl/kmd_queue.sv
// two-entry queue between the classifier and the modifier logic
// depends on kmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module kmd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire kmd_pkg::kmd_item_type push_item,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output kmd_pkg::kmd_item_type     pop_item
);
   import kmd_pkg::*;

   kmd_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/kmd_back.sv
// back part: debounce, sticky modifiers, fn layer, ascii, result register
// depends on kmd_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "keypad_matrix_decoder_sticky_modifiers_assert.svh"

module kmd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [15:0]          csr_data,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  wire kmd_pkg::kmd_item_type pop_item,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,
   output logic                      rsp_tuser
);
   import kmd_pkg::*;

   logic [15:0] debounce_ff;
   logic        shift_ff, shift_in;
   logic        fn_ff, fn_in;
   logic        shift_held_ff, shift_held_in;
   logic        fn_held_ff, fn_held_in;
   logic [31:0] last_ff, last_in;
   logic        rsp_valid_ff;
   logic        key_valid_ff, key_valid_in;
   logic [5:0]  code_ff, code_in;
   logic [6:0]  char_ff, char_in;
   logic        take;
   logic [31:0] elapsed;
   logic        in_window;
   logic [5:0]  mapped;

   assign csr_ready = 1'b1;
   assign pop_ready = !rsp_valid_ff || rsp_tready;
   assign take      = pop_valid && pop_ready;
   assign elapsed   = pop_item.now_ms - last_ff;
   assign in_window = elapsed < {16'd0, debounce_ff};

   always_comb begin
      shift_in      = shift_ff;
      fn_in         = fn_ff;
      shift_held_in = shift_held_ff;
      fn_held_in    = fn_held_ff;
      last_in       = last_ff;
      key_valid_in  = 1'b0;
      code_in       = 6'd0;
      char_in       = 7'd0;
      mapped        = pop_item.code;
      if (pop_item.action == ACT_CLEAR) begin
         shift_in = 1'b0;
         fn_in    = 1'b0;
      end else if (!in_window) begin
         if (pop_item.found && pop_item.code == KEY_FN) begin
            if (!fn_held_ff) begin
               fn_in      = !fn_ff;
               fn_held_in = 1'b1;
               last_in    = pop_item.now_ms;
            end
         end else begin
            fn_held_in = 1'b0;
            if (pop_item.found && pop_item.code == KEY_SHIFT) begin
               if (!shift_held_ff) begin
                  shift_in      = !shift_ff;
                  shift_held_in = 1'b1;
                  last_in       = pop_item.now_ms;
               end
            end else begin
               shift_held_in = 1'b0;
               if (pop_item.found) begin
                  if (fn_ff) begin
                     mapped = fn_layer(pop_item.code);
                     fn_in  = 1'b0;
                  end
                  last_in      = pop_item.now_ms;
                  key_valid_in = 1'b1;
                  code_in      = mapped;
                  if (mapped < KEY_PHYS_END) begin
                     char_in = shift_ff ? SHIFT_CHAR[mapped] : BASE_CHAR[mapped];
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         shift_ff      <= 1'b0;
         fn_ff         <= 1'b0;
         shift_held_ff <= 1'b0;
         fn_held_ff    <= 1'b0;
         last_ff       <= 32'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            debounce_ff <= csr_data;
         end
         if (take) begin
            shift_ff      <= shift_in;
            fn_ff         <= fn_in;
            shift_held_ff <= shift_held_in;
            fn_held_ff    <= fn_held_in;
            last_ff       <= last_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         key_valid_ff <= key_valid_in;
         code_ff      <= code_in;
         char_ff      <= char_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = key_valid_ff;
   // latches are read live: they only change when a new result is loaded
   assign rsp_tdata  = {1'b0, fn_ff, shift_ff, char_ff, code_ff};

   // consumed modifier keys are never reported
   `KMD_NEVER(a_no_modifier_event, clock, reset,
      rsp_valid_ff && key_valid_ff && (code_ff == KEY_FN || code_ff == KEY_SHIFT))
   // a reported key always leaves the fn latch cleared
   `KMD_NEVER(a_fn_clear_on_event, clock, reset, rsp_valid_ff && key_valid_ff && fn_ff)
   // a character only comes with an event
   `KMD_NEVER(a_char_needs_event, clock, reset,
      rsp_valid_ff && !key_valid_ff && (char_ff != 7'd0 || code_ff != 6'd0))
   // a clear request drops both latches
   `KMD_ASSERT(a_clear_drops_latches, clock, reset,
      (take && pop_item.action == ACT_CLEAR) |=> (!shift_ff && !fn_ff))

endmodule

`default_nettype wire

>>> hw/rtl/keypad_matrix_decoder_sticky_modifiers.sv
// top level of the keypad matrix decoder with sticky shift and fn latches
// depends on kmd_pkg, kmd_front, kmd_queue and kmd_back
//
//  channel  dir  handshake              tuser       tdata
//  req      in   req_tvalid/req_tready  action      key_matrix, now_ms
//  rsp      out  rsp_tvalid/rsp_tready  key_valid   key_code, ascii_char, shift_on, fn_on
//  csr      in   csr_valid/csr_ready    -           debounce_ms
//
// one request per cycle sustained while rsp_tready stays high
// the front priority encoder and the back modifier update are combinational logic
// a two-entry queue and the result register let the sides stall independently
// synchronous reset restores debounce_ms to 150 and clears latches and timestamp
// csr writes are always taken; the user must issue them only while the block is idle
`timescale 1ns / 1ps
`default_nettype none

module keypad_matrix_decoder_sticky_modifiers (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [87:0] req_tdata,   // [55:0] key_matrix, [87:56] now_ms
   input  wire logic        req_tuser,   // [0] action
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [5:0] key_code, [12:6] ascii_char,
                                         // [13] shift_on, [14] fn_on, [15] zero
   output logic             rsp_tuser,   // [0] key_valid
   // configuration channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data     // debounce_ms
);
   import kmd_pkg::*;

   kmd_item_type front_item;
   kmd_item_type back_item;
   logic         back_valid;
   logic         back_ready;

   // classify: find the lowest pressed switch and its key code
   kmd_front u_front (
      .req_action (req_tuser),
      .req_matrix (req_tdata[55:0]),
      .req_now_ms (req_tdata[87:56]),
      .item       (front_item)
   );

   // decouple the classifier from the modifier logic
   kmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_item  (front_item),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item)
   );

   // debounce, latch handling, fn layer, character lookup
   kmd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_item   (back_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// self-checking testbench for the keypad matrix decoder with sticky shift and fn
// depends on kmd_pkg and keypad_matrix_decoder_sticky_modifiers
// predicts every key event from the polls it sends and checks the response stream
`timescale 1ns / 1ps

module tb_top;
   import kmd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;

   // a few ordinary keys used by the directed part
   localparam logic [5:0] KEY_1     = 6'd1;
   localparam logic [5:0] KEY_Q     = 6'd15;
   localparam logic [5:0] KEY_P     = 6'd24;
   localparam logic [5:0] KEY_A     = 6'd30;
   localparam logic [5:0] KEY_SPACE = 6'd55;

   localparam logic [5:0] ARROW_KEYS [6] = '{
      KEY_SEMICOLON, KEY_PERIOD, KEY_COMMA, KEY_SLASH, KEY_BACKTICK, KEY_BACKSPACE
   };

   typedef struct packed {
      logic        action;
      logic [55:0] matrix;
      logic [31:0] now_ms;
   } poll_type;

   typedef struct packed {
      logic       key_valid;
      logic [5:0] key_code;
      logic [6:0] ascii_char;
      logic       shift_on;
      logic       fn_on;
   } key_event_type;

   // us layout by key code, row after row; a tab marks a key that prints nothing
   string plain_keys =
      "\1401234567890-=\t\tqwertyuiop[]\\\t\tasdfghjkl;'\t\t\t\tzxcvbnm,./ ";
   string shifted_keys =
      "~!@#$%^&*()_+\t\tQWERTYUIOP{}|\t\tASDFGHJKL:\"\t\t\t\tZXCVBNM<>? ";

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;   // [55:0] key_matrix, [87:56] now_ms
   logic        req_tuser = 1'b0; // [0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [5:0] key_code, [12:6] ascii_char, [13] shift_on, [14] fn_on
   logic        rsp_tuser;        // [0] key_valid
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   // predicted decoder state
   logic [15:0] debounce_window_ms = DEBOUNCE_RESET;
   logic        shift_latch = 1'b0;
   logic        fn_latch = 1'b0;
   logic        shift_held = 1'b0;
   logic        fn_held = 1'b0;
   logic [31:0] last_accept_ms = '0;

   poll_type      poll_queue[$];
   key_event_type pending_keys[$];
   poll_type      next_poll;
   int         polls_offered = 0;
   int         polls_taken = 0;
   int         mismatch_count = 0;
   int         cycle_count = 0;

   // idling percentages, changed only between phases
   int          sender_idle_pct = 7;
   int          receiver_idle_pct = 87;
   logic        hold_request = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_left = 0;

   logic [31:0] now_cursor = '0;
   logic [55:0] last_matrix = '0;

   keypad_matrix_decoder_sticky_modifiers u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one-hot switch snapshot for a key code (inverse of the scan mapping)
   function automatic logic [55:0] switch_of(input logic [5:0] code);
      int row;
      int col;
      int sel;
      row = int'(code) / 14;
      col = int'(code) % 14;
      sel = (3 - row) + ((col % 2 == 1) ? 0 : 4);
      return 56'd1 << (sel * 7 + col / 2);
   endfunction

   // decode one poll against the predicted latches, returns the expected event
   function automatic key_event_type decode_poll(input logic action,
                                                 input logic [55:0] matrix,
                                                 input logic [31:0] now_ms);
      key_event_type ev;
      logic       found;
      logic [5:0] code;
      logic [7:0] ch;
      int         sel;
      int         inl;
      ev = '0;
      found = 1'b0;
      code = '0;
      if (action == ACT_CLEAR) begin
         shift_latch = 1'b0;
         fn_latch = 1'b0;
      end else if ((now_ms - last_accept_ms) >= {16'd0, debounce_window_ms}) begin
         // lowest pressed switch wins
         for (int b = 0; b < 56; b++) begin
            if (!found && matrix[b]) begin
               found = 1'b1;
               sel = b / 7;
               inl = b % 7;
               code = 6'((3 - (sel % 4)) * 14 + 2 * inl + ((sel > 3) ? 0 : 1));
            end
         end
         if (found && code == KEY_FN) begin
            if (!fn_held) begin
               fn_latch = !fn_latch;
               fn_held = 1'b1;
               last_accept_ms = now_ms;
            end
         end else begin
            fn_held = 1'b0;
            if (found && code == KEY_SHIFT) begin
               if (!shift_held) begin
                  shift_latch = !shift_latch;
                  shift_held = 1'b1;
                  last_accept_ms = now_ms;
               end
            end else begin
               shift_held = 1'b0;
               if (found) begin
                  if (fn_latch) begin
                     case (code)
                        KEY_SEMICOLON: code = KEY_UP;
                        KEY_PERIOD:    code = KEY_DOWN;
                        KEY_COMMA:     code = KEY_LEFT;
                        KEY_SLASH:     code = KEY_RIGHT;
                        KEY_BACKTICK:  code = KEY_ESC;
                        KEY_BACKSPACE: code = KEY_DELETE;
                        default:       code = code;
                     endcase
                     fn_latch = 1'b0;
                  end
                  last_accept_ms = now_ms;
                  ch = 8'd0;
                  if (code < KEY_PHYS_END) begin
                     ch = shift_latch ? shifted_keys[code] : plain_keys[code];
                     if (ch == 8'h09) begin
                        ch = 8'd0;
                     end
                  end
                  ev.key_valid = 1'b1;
                  ev.key_code = code;
                  ev.ascii_char = ch[6:0];
               end
            end
         end
      end
      ev.shift_on = shift_latch;
      ev.fn_on = fn_latch;
      return ev;
   endfunction

   task automatic push_poll(input logic action, input logic [55:0] matrix,
                            input logic [31:0] now_ms);
      poll_queue.push_back('{action, matrix, now_ms});
   endtask

   // mostly well-formed key activity with time steps around the debounce window,
   // plus clear requests and raw noise snapshots
   task automatic queue_random_polls(input int count);
      int unsigned pick;
      logic [55:0] matrix;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         now_cursor += 32'($urandom_range(0, 2 * int'(debounce_window_ms) + 4));
         if (pick < 5) begin
            push_poll(ACT_CLEAR, 56'({$urandom, $urandom}), $urandom);
            continue;
         end
         if (pick < 15) begin
            now_cursor = $urandom;
            push_poll(ACT_POLL, 56'({$urandom, $urandom}), now_cursor);
            continue;
         end
         if (pick < 30) begin
            // key still held from the previous poll
            matrix = last_matrix;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               matrix = switch_of(KEY_FN);
            end else if (pick < 40) begin
               matrix = switch_of(KEY_SHIFT);
            end else if (pick < 50) begin
               matrix = '0;
            end else if (pick < 65) begin
               matrix = switch_of(ARROW_KEYS[$urandom_range(0, 5)]);
            end else begin
               matrix = switch_of(6'($urandom_range(0, 55)));
            end
            // extra keys above the one that should win
            if ($urandom_range(0, 99) < 15) begin
               matrix |= 56'({$urandom, $urandom}) & ~((matrix << 1) - 56'd1);
            end
         end
         last_matrix = matrix;
         push_poll(ACT_POLL, matrix, now_cursor);
      end
   endtask

   // block until every request is taken and every key event checked
   task automatic wait_drained();
      while (poll_queue.size() != 0 || polls_offered != polls_taken ||
             pending_keys.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   // only issued while the decoder is idle
   task automatic write_debounce(input logic [15:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      debounce_window_ms = value;
      @(negedge clock);
      csr_valid = 1'b0;
      @(posedge clock);
   endtask

   // request driver: offers the next pending poll at the falling edge
   always @(negedge clock) begin
      if (polls_offered == polls_taken) begin
         if (poll_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            next_poll = poll_queue.pop_front();
            req_tdata <= {next_poll.now_ms, next_poll.matrix};
            req_tuser <= next_poll.action;
            req_tvalid <= 1'b1;
            polls_offered = polls_offered + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // request accepted: run the prediction on exactly what the block took
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         pending_keys.push_back(decode_poll(req_tuser, req_tdata[55:0], req_tdata[87:56]));
         polls_taken = polls_taken + 1;
      end
   end

   // response ready: random idling, plus one long hold-off to back up the block
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // response monitor: each key event against the oldest prediction
   always @(posedge clock) begin
      key_event_type got;
      key_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.key_valid = rsp_tuser;
         got.key_code = rsp_tdata[5:0];
         got.ascii_char = rsp_tdata[12:6];
         got.shift_on = rsp_tdata[13];
         got.fn_on = rsp_tdata[14];
         if (pending_keys.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("unexpected key event: valid %0b code %0d char %02h shift %0b fn %0b",
                        got.key_valid, got.key_code, got.ascii_char, got.shift_on, got.fn_on);
            end
            mismatch_count++;
         end else begin
            want = pending_keys.pop_front();
            if (got.key_valid !== want.key_valid || got.key_code !== want.key_code ||
                got.ascii_char !== want.ascii_char || got.shift_on !== want.shift_on ||
                got.fn_on !== want.fn_on) begin
               if (mismatch_count < 10) begin
                  $display("mismatch: want valid %0b code %0d char %02h shift %0b fn %0b",
                           want.key_valid, want.key_code, want.ascii_char, want.shift_on,
                           want.fn_on);
                  $display("          got  valid %0b code %0d char %02h shift %0b fn %0b",
                           got.key_valid, got.key_code, got.ascii_char, got.shift_on,
                           got.fn_on);
               end
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // directed polls under the reset debounce of 150 ms
      push_poll(ACT_POLL, switch_of(KEY_Q), 32'd0);         // inside the window of time zero
      push_poll(ACT_POLL, 56'd0, 32'd200);                  // nothing pressed
      push_poll(ACT_POLL, {56{1'b1}}, 32'd400);             // every switch, lowest wins
      push_poll(ACT_POLL, 56'd1 << 55, 32'd600);            // top switch only
      push_poll(ACT_POLL, switch_of(KEY_FN), 32'd800);      // fn latches
      push_poll(ACT_POLL, switch_of(KEY_FN), 32'd1000);     // fn still held, no toggle
      push_poll(ACT_POLL, switch_of(KEY_SEMICOLON), 32'd1200);
      push_poll(ACT_POLL, switch_of(KEY_SHIFT), 32'd1400);
      push_poll(ACT_POLL, switch_of(KEY_A), 32'd1450);      // too soon after shift
      push_poll(ACT_POLL, switch_of(KEY_A), 32'd1600);
      push_poll(ACT_POLL, switch_of(KEY_1), 32'd1800);      // shift stays latched
      push_poll(ACT_POLL, switch_of(KEY_FN), 32'd2000);
      push_poll(ACT_POLL, switch_of(KEY_BACKTICK), 32'd2200);
      push_poll(ACT_POLL, switch_of(KEY_FN), 32'd2400);
      push_poll(ACT_POLL, switch_of(KEY_BACKSPACE), 32'd2600);
      push_poll(ACT_POLL, switch_of(KEY_FN), 32'd2800);
      push_poll(ACT_POLL, switch_of(KEY_PERIOD), 32'd3000);
      push_poll(ACT_POLL, switch_of(KEY_FN), 32'd3200);
      push_poll(ACT_POLL, switch_of(KEY_COMMA), 32'd3400);
      push_poll(ACT_POLL, switch_of(KEY_FN), 32'd3600);
      push_poll(ACT_POLL, switch_of(KEY_SLASH), 32'd3800);
      push_poll(ACT_POLL, switch_of(KEY_FN), 32'd4000);
      push_poll(ACT_CLEAR, switch_of(KEY_A), 32'd4010);     // clear both latches
      push_poll(ACT_POLL, switch_of(KEY_Q) | switch_of(KEY_P), 32'd4200);
      push_poll(ACT_POLL, switch_of(KEY_SHIFT), 32'hFFFF_FFF0);
      push_poll(ACT_POLL, switch_of(KEY_SPACE), 32'h0000_0050); // wrapped, still too soon
      push_poll(ACT_POLL, switch_of(KEY_SPACE), 32'h0000_0200);
      push_poll(ACT_POLL, switch_of(KEY_FN), 32'h0000_0400);
      push_poll(ACT_POLL, switch_of(KEY_Q), 32'h0000_0600);   // fn on a key with no layer
      now_cursor = 32'h0000_0800;
      wait_drained();

      // no debounce at all
      write_debounce(16'd0);
      queue_random_polls(280);
      wait_drained();

      // longest window, receiver mostly ready from here on
      sender_idle_pct = 87;
      receiver_idle_pct = 7;
      write_debounce(16'hFFFF);
      queue_random_polls(140);
      wait_drained();

      write_debounce(16'($urandom_range(1, 400)));
      queue_random_polls(140);
      wait_drained();

      // no idling; a long receiver hold-off fills the block and stalls requests,
      // then the sender waits for every result before the last stretch
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_debounce(16'd20);
      hold_request = 1'b1;
      queue_random_polls(140);
      wait_drained();
      queue_random_polls(140);
      wait_drained();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_keys.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
